### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, an active-low reset, the property parts and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/arsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_pkg
// Shared widths, codes and control types of the accelerating rate slew limiter.
// ----------------------------------------------------------------------------
package arsl_pkg;

	localparam int RATE_W        = 18;
	localparam int RANGE_W       = 17;
	localparam int CFG_IDX_W     = 1;
	localparam int FRACTION_BITS = 16;
	localparam int MUL_W         = 25;
	localparam int PROD_W        = 2 * MUL_W;
	// divide by 80: shift by 4, then multiply by ceil(2^25 / 5)
	localparam int DIV_PRE     = 4;
	localparam int DIV_Y_W     = 22;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 25;
	localparam int STEP_W      = 20;
	localparam logic [RECIP_W-1:0] RECIP       = 23'd6710887;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_RANGE = 1'b0,
		CFG_DIR_INV    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_THR,
		ST_DIV,
		ST_MOVE,
		ST_RNG,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MOP_SQR,
		MOP_THR,
		MOP_DIV,
		MOP_RNG
	} mul_op_t;

	typedef struct packed {
		logic    in_ready;
		logic    mul_en;
		mul_op_t mul_op;
		logic    ld_rate;
		logic    ld_out;
	} ctrl_t;

endpackage
`default_nettype wire

### rtl/arsl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_if
// Valid/ready channels carrying the target rate and the result transaction.
// ----------------------------------------------------------------------------
interface arsl_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [arsl_pkg::RATE_W-1:0]  target_rate;

	modport source (output valid, output target_rate, input ready);
	modport sink   (input valid, input target_rate, output ready);
endinterface

interface arsl_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [arsl_pkg::RATE_W-1:0]  rate_adjust;
	logic signed [arsl_pkg::RATE_W-1:0]  smoothed_rate;
	logic                                ramping;

	modport source (output valid, output rate_adjust, output smoothed_rate,
		output ramping, input ready);
	modport sink   (input valid, input rate_adjust, input smoothed_rate,
		input ramping, output ready);
endinterface
`default_nettype wire

### rtl/arsl_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module arsl_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [arsl_pkg::MUL_W-1:0]    a,
	input  logic signed [arsl_pkg::MUL_W-1:0]    b,
	output logic signed [arsl_pkg::PROD_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule
`default_nettype wire

### rtl/arsl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_ctrl
// Sequencer stepping one transaction through the shared multiplier.
// ----------------------------------------------------------------------------
module arsl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             ramp_now,
	input  logic             out_busy,
	output arsl_pkg::ctrl_t  ctrl
);

	arsl_pkg::state_t state_q;
	arsl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arsl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl.in_ready = 1'b0;
		ctrl.mul_en   = 1'b0;
		ctrl.mul_op   = arsl_pkg::MOP_SQR;
		ctrl.ld_rate  = 1'b0;
		ctrl.ld_out   = 1'b0;
		case (state_q)
			arsl_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (in_valid) begin
					state_d = ramp_now ? arsl_pkg::ST_SQR : arsl_pkg::ST_MOVE;
				end
			end
			arsl_pkg::ST_SQR: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = arsl_pkg::MOP_SQR;
				state_d     = arsl_pkg::ST_THR;
			end
			arsl_pkg::ST_THR: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = arsl_pkg::MOP_THR;
				state_d     = arsl_pkg::ST_DIV;
			end
			arsl_pkg::ST_DIV: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = arsl_pkg::MOP_DIV;
				state_d     = arsl_pkg::ST_MOVE;
			end
			arsl_pkg::ST_MOVE: begin
				ctrl.ld_rate = 1'b1;
				state_d      = arsl_pkg::ST_RNG;
			end
			arsl_pkg::ST_RNG: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = arsl_pkg::MOP_RNG;
				state_d     = arsl_pkg::ST_OUT;
			end
			arsl_pkg::ST_OUT: begin
				if (!out_busy) begin
					ctrl.ld_out = 1'b1;
					state_d     = arsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = arsl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/accelerating_rate_slew_limiter.sv
// A transaction steps through SQR, THR, DIV, MOVE, RNG and OUT when the rate slews,
// and through MOVE, RNG and OUT when it snaps; a new one is taken only back in IDLE.
// OUT waits while the last result is stalled. The one shared multiplier does square,
// threshold scale, divide by 80 and range scale in turn.
// Reset: smoothed rate and ramp count clear, range = full scale, not inverted.
`default_nettype none
// ----------------------------------------------------------------------------
// accelerating_rate_slew_limiter
// Slews a smoothed rate toward the target with a quadratically growing step,
// then scales it by the configured range, caps it and applies direction.
// ----------------------------------------------------------------------------
module accelerating_rate_slew_limiter #(
	parameter int RAMP_LIMIT    = 63
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [arsl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [arsl_pkg::RANGE_W-1:0]          cfg_data,
	arsl_in_if.sink                               in_ch,
	arsl_out_if.source                            out_ch
);

	localparam int RW     = arsl_pkg::RATE_W;
	localparam int GW     = arsl_pkg::RATE_W + 1;
	localparam int MW     = arsl_pkg::MUL_W;
	localparam int PW     = arsl_pkg::PROD_W;
	localparam int NW     = $clog2(RAMP_LIMIT + 1);
	localparam int CNT_W  = NW + 1;
	localparam int SQ_W   = 2 * NW;
	localparam int Y_LO   = arsl_pkg::DIV_PRE;
	localparam int Y_HI   = arsl_pkg::DIV_PRE + arsl_pkg::DIV_Y_W;
	localparam int SW     = arsl_pkg::STEP_W;
	localparam longint ONE_Q  = longint'(1) << arsl_pkg::FRACTION_BITS;
	localparam longint THRESH = (15 * ONE_Q + 500) / 1000;
	localparam longint CAP    = (99 * ONE_Q + 50) / 100;
	localparam logic [GW-1:0]           THRESH_G = GW'(THRESH);
	localparam logic signed [MW-1:0]    THRESH_M = MW'(THRESH);
	localparam logic signed [PW-1:0]    CAP_P    = PW'(CAP);
	localparam logic signed [PW-1:0]    LOW_P    = -PW'(131071);
	localparam logic signed [CNT_W-1:0] LIM_P    = CNT_W'(RAMP_LIMIT);
	localparam logic signed [CNT_W-1:0] LIM_N    = -CNT_W'(RAMP_LIMIT);
	localparam logic signed [CNT_W-1:0] ONE_C    = CNT_W'(1);

	arsl_pkg::ctrl_t                ctrl;
	logic [arsl_pkg::RANGE_W-1:0]   range_q;
	logic                           dir_q;
	logic signed [RW-1:0]           cur_q;
	logic signed [CNT_W-1:0]        cnt_q;
	logic signed [CNT_W-1:0]        cnt_d;
	logic signed [RW-1:0]           target_q;
	logic [GW-1:0]                  mag_q;
	logic                           up_q;
	logic                           ramp_q;
	logic                           accept;
	logic signed [GW-1:0]           gap;
	logic [GW-1:0]                  mag;
	logic                           ramp_now;
	logic                           up_now;
	logic [CNT_W-1:0]               n_abs;
	logic [NW-1:0]                  n;
	logic [arsl_pkg::DIV_Y_W-1:0]   y;
	logic signed [MW-1:0]           mul_a;
	logic signed [MW-1:0]           mul_b;
	logic signed [PW-1:0]           p_q;
	logic [SW-1:0]                  step;
	logic signed [RW-1:0]           cur_d;
	logic signed [PW-1:0]           scaled;
	logic signed [PW-1:0]           capped;
	logic signed [PW-1:0]           adj;
	logic                           out_busy;
	logic                           out_valid_q;
	logic signed [RW-1:0]           rate_adjust_q;
	logic signed [RW-1:0]           smoothed_q;
	logic                           ramping_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= arsl_pkg::RANGE_RESET;
			dir_q   <= 1'b0;
		end else if (cfg_we) begin
			case (arsl_pkg::cfg_reg_t'(cfg_index))
				arsl_pkg::CFG_RATE_RANGE: range_q <= cfg_data;
				arsl_pkg::CFG_DIR_INV:    dir_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept   = ctrl.in_ready && in_ch.valid;
	assign gap      = {in_ch.target_rate[RW-1], in_ch.target_rate} - {cur_q[RW-1], cur_q};
	assign mag      = gap[GW-1] ? GW'(-gap) : GW'(gap);
	assign ramp_now = mag > THRESH_G;
	assign up_now   = !gap[GW-1];

	// ramp counter: clear when not ramping, restart on direction change, saturate at the limit
	always_comb begin
		cnt_d = '0;
		if (ramp_now) begin
			if (up_now) begin
				if (cnt_q > 0) begin
					cnt_d = (cnt_q == LIM_P) ? LIM_P : cnt_q + ONE_C;
				end else begin
					cnt_d = ONE_C;
				end
			end else begin
				if (cnt_q < 0) begin
					cnt_d = (cnt_q == LIM_N) ? LIM_N : cnt_q - ONE_C;
				end else begin
					cnt_d = -ONE_C;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= in_ch.target_rate;
			mag_q    <= mag;
			up_q     <= up_now;
			ramp_q   <= ramp_now;
		end
	end

	assign n_abs = cnt_q[CNT_W-1] ? CNT_W'(-cnt_q) : CNT_W'(cnt_q);
	assign n     = n_abs[NW-1:0];
	assign y     = (|p_q[PW-1:Y_HI]) ? '1 : p_q[Y_HI-1:Y_LO];

	always_comb begin
		case (ctrl.mul_op)
			arsl_pkg::MOP_SQR: begin
				mul_a = MW'(n);
				mul_b = MW'(n);
			end
			arsl_pkg::MOP_THR: begin
				mul_a = THRESH_M;
				mul_b = MW'(p_q[SQ_W-1:0]);
			end
			arsl_pkg::MOP_DIV: begin
				mul_a = MW'(y);
				mul_b = MW'(arsl_pkg::RECIP);
			end
			arsl_pkg::MOP_RNG: begin
				mul_a = MW'(cur_q);
				mul_b = MW'(range_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	arsl_mul u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// move toward the target without passing it
	assign step = p_q[arsl_pkg::RECIP_SHIFT+SW-1:arsl_pkg::RECIP_SHIFT];

	always_comb begin
		if (!ramp_q || (step >= SW'(mag_q))) begin
			cur_d = target_q;
		end else if (up_q) begin
			cur_d = cur_q + RW'(step);
		end else begin
			cur_d = cur_q - RW'(step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
			end
			if (ctrl.ld_rate) begin
				cur_q <= cur_d;
			end
		end
	end

	assign scaled = p_q >>> arsl_pkg::FRACTION_BITS;

	always_comb begin
		if (scaled > CAP_P) begin
			capped = CAP_P;
		end else if (scaled < LOW_P) begin
			capped = LOW_P;
		end else begin
			capped = scaled;
		end
		adj = dir_q ? -capped : capped;
	end

	assign out_busy = out_valid_q && !out_ch.ready;

	arsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.ramp_now (ramp_now),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			rate_adjust_q <= adj[RW-1:0];
			smoothed_q    <= cur_q;
			ramping_q     <= ramp_q;
		end
	end

	assign in_ch.ready          = ctrl.in_ready;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.rate_adjust   = rate_adjust_q;
	assign out_ch.smoothed_rate = smoothed_q;
	assign out_ch.ramping       = ramping_q;

endmodule
`default_nettype wire

### rtl/arsl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_checker
// Port-level checks of the slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arsl_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [arsl_pkg::RATE_W-1:0]   rate_adjust,
	input logic signed [arsl_pkg::RATE_W-1:0]   smoothed_rate,
	input logic                                 ramping
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rate_adjust) && $stable(smoothed_rate) && $stable(ramping), "stalled result changed")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready while a transaction is in work")
	`ASSERT_SAME(a_result_from_work, clk, arst_n, $rose(out_valid), $past(!in_ready), "result appeared without work")
	`ASSERT_SAME(a_zero_rate_zero_adj, clk, arst_n, out_valid && (smoothed_rate == '0), rate_adjust == '0, "nonzero adjust for zero rate")

endmodule

bind accelerating_rate_slew_limiter arsl_checker u_arsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.rate_adjust   (out_ch.rate_adjust),
	.smoothed_rate (out_ch.smoothed_rate),
	.ramping       (out_ch.ramping)
);
`default_nettype wire
